// ===== hw/rtl/msd_pkg.sv =====
// Shared types and constants of the MESI sharer directory.
`timescale 1ns / 1ps
package msd_pkg;

   localparam int LINE_INDEX_W = 10;
   localparam int ADDR_W       = 48;
   localparam int CHILD_W      = 4;
   localparam int MASK_MAX_W   = 16;
   localparam int TOTAL_W      = 5;
   localparam int CSR_DATA_W   = 5;

   typedef enum logic [2:0] {
      OP_GETS  = 3'd0,
      OP_GETX  = 3'd1,
      OP_PUTS  = 3'd2,
      OP_PUTX  = 3'd3,
      OP_EVICT = 3'd4,
      OP_INV   = 3'd5,
      OP_INVX  = 3'd6,
      OP_FWD   = 3'd7
   } op_type;

   localparam logic [2:0] GRANT_UNCHANGED = 3'd0;
   localparam logic [2:0] GRANT_I         = 3'd1;
   localparam logic [2:0] GRANT_S         = 3'd2;
   localparam logic [2:0] GRANT_E         = 3'd3;
   localparam logic [2:0] GRANT_M         = 3'd4;

   localparam logic KIND_INVALIDATE = 1'b0;
   localparam logic KIND_DOWNGRADE  = 1'b1;

   localparam logic CSR_NON_INCLUSIVE = 1'b0;
   localparam logic CSR_CHILD_COUNT   = 1'b1;

   localparam logic [CSR_DATA_W-1:0] CHILD_COUNT_RESET = 5'd16;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_READY,
      ST_LOOKUP,
      ST_DECIDE,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic lookup;
      logic decide;
      logic emit_msg;
      logic emit_done;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic msg_pending;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/msd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module msd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/msd_controller.sv =====
// Sequencing state machine of the MESI sharer directory.
`timescale 1ns / 1ps
module msd_controller
   import msd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) begin
               state_in = ST_READY;
            end
         end
         ST_READY: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_SEND;
         ST_SEND: begin
            if (status.out_free && !status.msg_pending) begin
               state_in = ST_READY;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR:  cmd.clear_wr = 1'b1;
         ST_READY: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_LOOKUP: cmd.lookup = 1'b1;
         ST_DECIDE: cmd.decide = 1'b1;
         ST_SEND: begin
            cmd.emit_msg  = status.out_free && status.msg_pending;
            cmd.emit_done = status.out_free && !status.msg_pending;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_starts_lookup: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_LOOKUP))
      else $error("Accepted request did not start a lookup.");

   a_msg_needs_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_msg |-> status.msg_pending)
      else $error("Message emitted with no sharer left to notify.");

   a_clear_ends_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && status.clear_last) |=> (state_ff == ST_READY))
      else $error("Clearing pass did not hand over to the ready state.");

endmodule

// ===== hw/rtl/msd_datapath.sv =====
// Datapath of the MESI sharer directory: entry store, update logic and result register.
`timescale 1ns / 1ps
module msd_datapath
   import msd_pkg::*;
#(
   parameter int NUM_LINES    = 1024,
   parameter int NUM_CHILDREN = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   input  logic [2:0]              req_operation,
   input  logic [LINE_INDEX_W-1:0] req_line_index,
   input  logic [ADDR_W-1:0]       req_line_address,
   input  logic [CHILD_W-1:0]      req_requester_child,
   input  logic                    req_have_exclusive,
   input  logic [1:0]              req_request_flags,
   input  logic                    csr_wr_en,
   input  logic                    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wr_data,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic                    rsp_is_invalidate,
   output logic [CHILD_W-1:0]      rsp_target_child,
   output logic                    rsp_inval_kind,
   output logic [ADDR_W-1:0]       rsp_message_address,
   output logic [2:0]              rsp_granted_state,
   output logic                    rsp_last
);

   localparam int AW      = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
   localparam int MASK_W  = (NUM_CHILDREN < MASK_MAX_W) ? NUM_CHILDREN : MASK_MAX_W;
   localparam int ENTRY_W = MASK_W + TOTAL_W + 1;

   function automatic logic [AW-1:0] reduce_index(input logic [LINE_INDEX_W-1:0] raw);
      logic [31:0] rem;
      rem = 32'(raw);
      for (int k = LINE_INDEX_W - 1; k >= 0; k--) begin
         if (rem >= (32'(NUM_LINES) << k)) begin
            rem = rem - (32'(NUM_LINES) << k);
         end
      end
      return rem[AW-1:0];
   endfunction

   function automatic logic [CHILD_W-1:0] lowest_set(input logic [MASK_MAX_W-1:0] vec);
      logic [CHILD_W-1:0] pos;
      pos = '0;
      for (int c = MASK_MAX_W - 1; c >= 0; c--) begin
         if (vec[c]) begin
            pos = CHILD_W'(c);
         end
      end
      return pos;
   endfunction

   // Captured request and configuration.
   op_type                  op_ff, op_in;
   logic [AW-1:0]           idx_ff, idx_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [CHILD_W-1:0]      child_ff, child_in;
   logic                    excl_ff, excl_in;
   logic [1:0]              flags_ff, flags_in;
   logic                    non_incl_ff, non_incl_in;
   logic [CSR_DATA_W-1:0]   child_count_ff, child_count_in;

   // Work registers.
   logic [AW-1:0]           clr_addr_ff, clr_addr_in;
   logic [MASK_MAX_W-1:0]   msg_ff, msg_in;
   logic                    kind_ff, kind_in;
   logic [2:0]              granted_ff, granted_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_inv_ff, rsp_inv_in;
   logic [CHILD_W-1:0]      rsp_target_ff, rsp_target_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;
   logic [2:0]              rsp_granted_ff, rsp_granted_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Entry store.
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [ENTRY_W-1:0]      ram_wr_data;
   logic [ENTRY_W-1:0]      ram_rd_data;

   // Update logic.
   logic [MASK_MAX_W-1:0]   cur_mask;
   logic [TOTAL_W-1:0]      cur_total;
   logic                    cur_mark;
   logic [MASK_MAX_W-1:0]   new_mask;
   logic [TOTAL_W-1:0]      new_total;
   logic                    new_mark;
   logic [MASK_MAX_W-1:0]   send_mask;
   logic                    send_kind;
   logic [2:0]              grant;
   logic [TOTAL_W-1:0]      n_use;
   logic [MASK_MAX_W-1:0]   use_mask;
   logic [MASK_MAX_W-1:0]   child_bit;
   logic                    child_in_use;

   msd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_LINES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.lookup),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign cur_mask  = MASK_MAX_W'(ram_rd_data[MASK_W-1:0]);
   assign cur_total = ram_rd_data[MASK_W +: TOTAL_W];
   assign cur_mark  = ram_rd_data[ENTRY_W-1];

   assign n_use        = (child_count_ff > TOTAL_W'(MASK_W)) ? TOTAL_W'(MASK_W) : child_count_ff;
   assign use_mask     = ~({MASK_MAX_W{1'b1}} << n_use);
   assign child_bit    = MASK_MAX_W'(1) << child_ff;
   assign child_in_use = (TOTAL_W'(child_ff) < n_use);

   always_comb begin
      new_mask  = cur_mask;
      new_total = cur_total;
      new_mark  = cur_mark;
      send_mask = '0;
      send_kind = KIND_INVALIDATE;
      grant     = GRANT_UNCHANGED;
      if (op_ff <= OP_PUTX && !child_in_use) begin
         grant = GRANT_UNCHANGED;
      end else begin
         unique case (op_ff)
            OP_GETS: begin
               if (cur_total == '0 && excl_ff && !flags_ff[1]) begin
                  new_mask  = cur_mask | child_bit;
                  new_total = TOTAL_W'(1);
                  new_mark  = 1'b1;
                  grant     = GRANT_E;
               end else begin
                  if (cur_mark && cur_total == TOTAL_W'(1)) begin
                     send_mask = cur_mask & use_mask;
                     send_kind = KIND_DOWNGRADE;
                  end
                  if ((cur_mask & child_bit) == '0) begin
                     new_mask = cur_mask | child_bit;
                     if (cur_total != '1) begin
                        new_total = cur_total + TOTAL_W'(1);
                     end
                  end
                  new_mark = 1'b0;
                  grant    = GRANT_S;
               end
            end
            OP_GETX: begin
               if ((new_mask & child_bit) != '0) begin
                  new_mask = new_mask & ~child_bit;
                  if (new_total != '0) begin
                     new_total = new_total - TOTAL_W'(1);
                  end
               end
               if (new_total != '0) begin
                  send_mask = new_mask & use_mask;
                  new_mask  = '0;
                  new_total = '0;
               end
               if ((new_mask & child_bit) == '0) begin
                  new_mask = new_mask | child_bit;
                  if (new_total != '1) begin
                     new_total = new_total + TOTAL_W'(1);
                  end
               end
               new_mark = 1'b1;
               grant    = GRANT_M;
            end
            OP_PUTS, OP_PUTX: begin
               if (op_ff == OP_PUTX && flags_ff[0]) begin
                  grant = GRANT_E;
               end else begin
                  if (cur_total != '0 && (cur_mask & child_bit) != '0) begin
                     new_mask  = cur_mask & ~child_bit;
                     new_total = cur_total - TOTAL_W'(1);
                  end
                  grant = GRANT_I;
               end
            end
            OP_EVICT: begin
               if (non_incl_ff) begin
                  new_mask  = '0;
                  new_total = '0;
                  new_mark  = 1'b0;
               end else if (cur_total != '0) begin
                  send_mask = cur_mask & use_mask;
                  new_mask  = '0;
                  new_total = '0;
               end
            end
            OP_INV: begin
               if (cur_total != '0) begin
                  send_mask = cur_mask & use_mask;
                  new_mask  = '0;
                  new_total = '0;
               end
            end
            OP_INVX: begin
               if (cur_mark && cur_total == TOTAL_W'(1)) begin
                  send_mask = cur_mask & use_mask;
                  send_kind = KIND_DOWNGRADE;
                  new_mark  = 1'b0;
               end
            end
            OP_FWD: grant = GRANT_UNCHANGED;
         endcase
      end
   end

   assign ram_wr_en   = cmd.clear_wr || cmd.decide;
   assign ram_wr_addr = cmd.clear_wr ? clr_addr_ff : idx_ff;
   assign ram_wr_data = cmd.clear_wr ? '0 : {new_mark, new_total, new_mask[MASK_W-1:0]};

   always_comb begin
      op_in          = op_ff;
      idx_in         = idx_ff;
      addr_in        = addr_ff;
      child_in       = child_ff;
      excl_in        = excl_ff;
      flags_in       = flags_ff;
      non_incl_in    = non_incl_ff;
      child_count_in = child_count_ff;
      clr_addr_in    = clr_addr_ff;
      msg_in         = msg_ff;
      kind_in        = kind_ff;
      granted_in     = granted_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_inv_in     = rsp_inv_ff;
      rsp_target_in  = rsp_target_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NON_INCLUSIVE: non_incl_in    = csr_wr_data[0];
            CSR_CHILD_COUNT:   child_count_in = csr_wr_data;
         endcase
      end
      if (cmd.clear_wr) begin
         clr_addr_in = clr_addr_ff + AW'(1);
      end
      if (cmd.capture) begin
         op_in    = op_type'(req_operation);
         idx_in   = reduce_index(req_line_index);
         addr_in  = req_line_address;
         child_in = req_requester_child;
         excl_in  = req_have_exclusive;
         flags_in = req_request_flags;
      end
      if (cmd.decide) begin
         msg_in     = send_mask;
         kind_in    = send_kind;
         granted_in = grant;
      end
      if (cmd.emit_msg) begin
         msg_in         = msg_ff & (msg_ff - MASK_MAX_W'(1));
         rsp_valid_in   = 1'b1;
         rsp_inv_in     = 1'b1;
         rsp_target_in  = lowest_set(msg_ff);
         rsp_kind_in    = kind_ff;
         rsp_addr_in    = addr_ff;
         rsp_granted_in = GRANT_UNCHANGED;
         rsp_last_in    = 1'b0;
      end
      if (cmd.emit_done) begin
         rsp_valid_in   = 1'b1;
         rsp_inv_in     = 1'b0;
         rsp_target_in  = '0;
         rsp_kind_in    = KIND_INVALIDATE;
         rsp_addr_in    = addr_ff;
         rsp_granted_in = granted_ff;
         rsp_last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         non_incl_ff    <= 1'b0;
         child_count_ff <= CHILD_COUNT_RESET;
         clr_addr_ff    <= '0;
         msg_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         non_incl_ff    <= non_incl_in;
         child_count_ff <= child_count_in;
         clr_addr_ff    <= clr_addr_in;
         msg_ff         <= msg_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff          <= op_in;
      idx_ff         <= idx_in;
      addr_ff        <= addr_in;
      child_ff       <= child_in;
      excl_ff        <= excl_in;
      flags_ff       <= flags_in;
      kind_ff        <= kind_in;
      granted_ff     <= granted_in;
      rsp_inv_ff     <= rsp_inv_in;
      rsp_target_ff  <= rsp_target_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_addr_ff    <= rsp_addr_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign status.clear_last  = (clr_addr_ff == AW'(NUM_LINES - 1));
   assign status.msg_pending = (msg_ff != '0);
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_invalidate   = rsp_inv_ff;
   assign rsp_target_child    = rsp_target_ff;
   assign rsp_inval_kind      = rsp_kind_ff;
   assign rsp_message_address = rsp_addr_ff;
   assign rsp_granted_state   = rsp_granted_ff;
   assign rsp_last            = rsp_last_ff;

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_done |=> (rsp_valid && rsp_last && !rsp_is_invalidate))
      else $error("Completion was not presented as the final result.");

   a_target_in_use: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_invalidate) |-> (TOTAL_W'(rsp_target_child) < n_use))
      else $error("Invalidation sent to a child that is not in use.");

   a_msg_not_last: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_msg |=> (rsp_valid && !rsp_last))
      else $error("Invalidation message marked as the final result.");

endmodule

// ===== hw/rtl/mesi_sharer_directory_unit.sv =====
// Top level of the MESI sharer directory: controller and datapath.
`timescale 1ns / 1ps
// Sharer directory for the child caches under one cache level. Each line entry
// holds a sharer mask, a sharer count and an exclusive mark in a single RAM.
// After reset the block sweeps the RAM to zero, one entry per cycle, so it
// accepts no request until the sweep has written the last entry; configuration
// writes are taken during that time. Each accepted request is captured, then
// its entry is read through the registered RAM read and updated, and then its
// invalidate or downgrade messages (0 to 16) and a completion go out through
// the result register before the next request is accepted. The messages go
// out one per cycle while the result register is free, in ascending child
// order, and are followed by a completion carrying the granted state with
// rsp_last set.
module mesi_sharer_directory_unit
   import msd_pkg::*;
#(
   parameter int NUM_LINES    = 1024,
   parameter int NUM_CHILDREN = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_operation,
   input  logic [LINE_INDEX_W-1:0] req_line_index,
   input  logic [ADDR_W-1:0]       req_line_address,
   input  logic [CHILD_W-1:0]      req_requester_child,
   input  logic                    req_have_exclusive,
   input  logic [1:0]              req_request_flags,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_is_invalidate,
   output logic [CHILD_W-1:0]      rsp_target_child,
   output logic                    rsp_inval_kind,
   output logic [ADDR_W-1:0]       rsp_message_address,
   output logic [2:0]              rsp_granted_state,
   output logic                    rsp_last,
   input  logic                    csr_wr_en,
   input  logic                    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   msd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   msd_datapath #(
      .NUM_LINES    (NUM_LINES),
      .NUM_CHILDREN (NUM_CHILDREN)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_operation),
      .req_line_index      (req_line_index),
      .req_line_address    (req_line_address),
      .req_requester_child (req_requester_child),
      .req_have_exclusive  (req_have_exclusive),
      .req_request_flags   (req_request_flags),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_is_invalidate   (rsp_is_invalidate),
      .rsp_target_child    (rsp_target_child),
      .rsp_inval_kind      (rsp_inval_kind),
      .rsp_message_address (rsp_message_address),
      .rsp_granted_state   (rsp_granted_state),
      .rsp_last            (rsp_last)
   );

endmodule
